FILE: sv/tfn_pkg.sv
// Shared widths, stage map and payload types of the triangle face normal pipeline.
package tfn_pkg;

  localparam int CoordW  = 24;
  localparam int FracW   = 15;
  localparam int OutW    = FracW + 1;
  localparam int EdgeW   = CoordW + 1;
  localparam int ProdW   = 2 * EdgeW;
  localparam int CrossW  = ProdW + 1;
  localparam int MagW    = CrossW;
  localparam int BlW     = $clog2(MagW + 1);
  localparam int KeepW   = 30;
  localparam int SqW     = 2 * KeepW;
  localparam int SumW    = 2 * KeepW + 2;
  localparam int RootW   = KeepW + 1;
  localparam int QuoW    = FracW + 1;
  localparam int DivW    = KeepW + FracW + 1;
  localparam int DegBits = 16;
  localparam int ThrW    = 32;
  localparam int StepN   = 4;

  localparam int FrontStages = 4;
  localparam int NormStages  = 5;
  localparam int SqStages    = (RootW + StepN - 1) / StepN;
  localparam int DivStages   = (QuoW + StepN - 1) / StepN;
  localparam int NormBase    = FrontStages;
  localparam int SqBase      = NormBase + NormStages;
  localparam int DivBase     = SqBase + SqStages;
  localparam int OutIdx      = DivBase + DivStages + 1;
  localparam int NumStages   = OutIdx + 1;

  localparam int AddrW = 3;
  localparam logic RegThr = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v0_z;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
  } tfn_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } tfn_out_t;

endpackage

FILE: sv/tfn_front.sv
// Edge vectors, cross product and component magnitudes, four register stages.
module tfn_front import tfn_pkg::*; (
  input  logic                       clk_i,
  input  logic [FrontStages-1:0]     en_i,
  input  tfn_in_t                    tri_i,
  output logic [2:0][MagW-1:0]       mag_o,
  output logic [2:0]                 neg_o
);

  logic signed [EdgeW-1:0]  ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [ProdW-1:0]  p_q [6];
  logic signed [CrossW-1:0] n_q [3];
  logic [2:0][MagW-1:0]     mag_q;
  logic [2:0]               neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ax_q <= EdgeW'(tri_i.v1_x) - EdgeW'(tri_i.v0_x);
      ay_q <= EdgeW'(tri_i.v1_y) - EdgeW'(tri_i.v0_y);
      az_q <= EdgeW'(tri_i.v1_z) - EdgeW'(tri_i.v0_z);
      bx_q <= EdgeW'(tri_i.v2_x) - EdgeW'(tri_i.v0_x);
      by_q <= EdgeW'(tri_i.v2_y) - EdgeW'(tri_i.v0_y);
      bz_q <= EdgeW'(tri_i.v2_z) - EdgeW'(tri_i.v0_z);
    end
    if (en_i[1]) begin
      p_q[0] <= ProdW'(ay_q) * ProdW'(bz_q);
      p_q[1] <= ProdW'(az_q) * ProdW'(by_q);
      p_q[2] <= ProdW'(az_q) * ProdW'(bx_q);
      p_q[3] <= ProdW'(ax_q) * ProdW'(bz_q);
      p_q[4] <= ProdW'(ax_q) * ProdW'(by_q);
      p_q[5] <= ProdW'(ay_q) * ProdW'(bx_q);
    end
    if (en_i[2]) begin
      n_q[0] <= CrossW'(p_q[0]) - CrossW'(p_q[1]);
      n_q[1] <= CrossW'(p_q[2]) - CrossW'(p_q[3]);
      n_q[2] <= CrossW'(p_q[4]) - CrossW'(p_q[5]);
    end
    if (en_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= n_q[i][CrossW-1];
        mag_q[i] <= n_q[i][CrossW-1] ? (~MagW'(n_q[i]) + MagW'(1)) : MagW'(n_q[i]);
      end
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

FILE: sv/tfn_norm.sv
// Block scaling of the magnitudes, squared length and degenerate test, five stages.
module tfn_norm import tfn_pkg::*; (
  input  logic                    clk_i,
  input  logic [NormStages-1:0]   en_i,
  input  logic [2:0][MagW-1:0]    mag_i,
  input  logic [2:0]              neg_i,
  input  logic [ThrW-1:0]         thr_i,
  output logic [SumW-1:0]         sum_o,
  output logic [2:0][KeepW-1:0]   c_o,
  output logic [2:0]              neg_o,
  output logic                    deg_o
);

  logic [MagW-1:0]        orv;
  logic [BlW-1:0]         bl_d, bl_q, sh;
  logic [2:0][MagW-1:0]   m1_q;
  logic [2:0]             neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [2:0][KeepW-1:0]  c2_q, c3_q, c4_q, c5_q;
  logic                   small2_q, small3_q, small4_q;
  logic [SqW-1:0]         sq_q [3];
  logic [SumW-1:0]        sum4_q, sum5_q;
  logic                   deg5_q;

  assign orv = mag_i[0] | mag_i[1] | mag_i[2];

  // bit length of the largest magnitude
  always_comb begin
    bl_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) bl_d = BlW'(i + 1);
    end
  end

  assign sh = (bl_q > BlW'(KeepW)) ? (bl_q - BlW'(KeepW)) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      bl_q   <= bl_d;
      m1_q   <= mag_i;
      neg1_q <= neg_i;
    end
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) c2_q[i] <= KeepW'(m1_q[i] >> sh);
      neg2_q   <= neg1_q;
      small2_q <= (bl_q <= BlW'(DegBits));
    end
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= SqW'(c2_q[i]) * SqW'(c2_q[i]);
      c3_q     <= c2_q;
      neg3_q   <= neg2_q;
      small3_q <= small2_q;
    end
    if (en_i[3]) begin
      sum4_q   <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      c4_q     <= c3_q;
      neg4_q   <= neg3_q;
      small4_q <= small3_q;
    end
    if (en_i[4]) begin
      // unscaled sum equals the exact squared length whenever it is small
      deg5_q <= small4_q && (sum4_q <= SumW'(thr_i));
      sum5_q <= sum4_q;
      c5_q   <= c4_q;
      neg5_q <= neg4_q;
    end
  end

  assign sum_o = sum5_q;
  assign c_o   = c5_q;
  assign neg_o = neg5_q;
  assign deg_o = deg5_q;

endmodule

FILE: sv/tfn_isqrt.sv
// Pipelined integer square root, a few result bits per stage.
module tfn_isqrt import tfn_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                  clk_i,
  input  logic [SqStages-1:0]   en_i,
  input  logic [SumW-1:0]       x_i,
  input  logic [SideW-1:0]      side_i,
  output logic [RootW-1:0]      root_o,
  output logic [SideW-1:0]      side_o
);

  logic [RootW:0]    rem_q  [SqStages];
  logic [RootW-1:0]  root_q [SqStages];
  logic [SumW-1:0]   x_q    [SqStages];
  logic [SideW-1:0]  side_q [SqStages];

  for (genvar k = 0; k < SqStages; k++) begin : g_st
    logic [RootW:0]   rem_in, rem_d;
    logic [RootW-1:0] root_in, root_d;
    logic [SumW-1:0]  x_in, x_d;
    logic [SideW-1:0] side_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      logic [RootW+2:0] r2;
      logic [RootW+2:0] tr;
      r2     = '0;
      tr     = '0;
      rem_d  = rem_in;
      root_d = root_in;
      x_d    = x_in;
      for (int j = 0; j < StepN; j++) begin
        if (k * StepN + j < RootW) begin
          r2 = {rem_d, x_d[SumW-1 -: 2]};
          tr = (RootW+3)'({root_d, 2'b01});
          if (r2 >= tr) begin
            rem_d  = (RootW+1)'(r2 - tr);
            root_d = {root_d[RootW-2:0], 1'b1};
          end else begin
            rem_d  = (RootW+1)'(r2);
            root_d = {root_d[RootW-2:0], 1'b0};
          end
          x_d = {x_d[SumW-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        x_q[k]    <= x_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = root_q[SqStages-1];
  assign side_o = side_q[SqStages-1];

endmodule

FILE: sv/tfn_div.sv
// Rounded quotient of three components by the length, restoring division in stages.
module tfn_div import tfn_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                    clk_i,
  input  logic [DivStages:0]      en_i,
  input  logic [RootW-1:0]        root_i,
  input  logic [2:0][KeepW-1:0]   c_i,
  input  logic [SideW-1:0]        side_i,
  output logic [2:0][QuoW-1:0]    q_o,
  output logic [SideW-1:0]        side_o
);

  logic [RootW-1:0]            r_q    [DivStages+1];
  logic [2:0][RootW-1:0]       rem_q  [DivStages+1];
  logic [2:0][QuoW-1:0]        lo_q   [DivStages+1];
  logic [SideW-1:0]            side_q [DivStages+1];

  logic [RootW-1:0]      r0;
  logic [2:0][DivW-1:0]  dvd;

  // dividend is c * 2^frac plus half the divisor, for round to nearest
  always_comb begin
    r0 = (root_i == '0) ? RootW'(1) : root_i;
    for (int l = 0; l < 3; l++) begin
      dvd[l] = (DivW'(c_i[l]) << FracW) + DivW'(r0 >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]    <= r0;
      side_q[0] <= side_i;
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= RootW'(dvd[l][DivW-1:QuoW]);
        lo_q[0][l]  <= dvd[l][QuoW-1:0];
      end
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_st
    logic [2:0][RootW-1:0] rem_d;
    logic [2:0][QuoW-1:0]  lo_d;

    always_comb begin
      logic [RootW:0] t;
      t     = '0;
      rem_d = rem_q[k-1];
      lo_d  = lo_q[k-1];
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < StepN; j++) begin
          if ((k - 1) * StepN + j < QuoW) begin
            t = {rem_d[l], lo_d[l][QuoW-1]};
            if (t >= {1'b0, r_q[k-1]}) begin
              rem_d[l] = RootW'(t - {1'b0, r_q[k-1]});
              lo_d[l]  = {lo_d[l][QuoW-2:0], 1'b1};
            end else begin
              rem_d[l] = RootW'(t);
              lo_d[l]  = {lo_d[l][QuoW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        r_q[k]    <= r_q[k-1];
        rem_q[k]  <= rem_d;
        lo_q[k]   <= lo_d;
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign q_o    = lo_q[DivStages];
  assign side_o = side_q[DivStages];

endmodule

FILE: sv/triangle_face_normal.sv
// Unit face normal of one triangle per transfer, fully pipelined: a new triangle may enter
// every cycle unless in_stall_o is raised by a stall at the output. The square root and
// division stages resolve up to four result bits each; bubbles collapse while the output
// is stalled. The threshold register at byte address 0 holds the squared cross-product
// length at or below which a triangle is reported degenerate with a zero normal; write it
// only while the pipeline is empty.
module triangle_face_normal import tfn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfn_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfn_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SqSideW = 3 * KeepW + 4;

  logic [ThrW-1:0]       thr_q;
  logic [NumStages-1:0]  v_q, en;

  logic [2:0][MagW-1:0]  mag;
  logic [2:0]            fneg, nneg, dneg;
  logic [SumW-1:0]       sum;
  logic [2:0][KeepW-1:0] cval;
  logic                  ndeg, ddeg;
  logic [SqSideW-1:0]    sq_side_in, sq_side_out;
  logic [RootW-1:0]      root;
  logic [2:0][QuoW-1:0]  quo;
  tfn_out_t              out_d, out_q;

  localparam logic [OutW-1:0] OneCode = {1'b1, {FracW{1'b0}}};
  localparam logic [OutW-1:0] MaxCode = {1'b0, {FracW{1'b1}}};

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1] == RegThr) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[AddrW-1] == RegThr)) begin
      thr_q <= pwdata;
    end
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  tfn_front u_front (
    .clk_i (clk_i),
    .en_i  (en[FrontStages-1:0]),
    .tri_i (in_data_i),
    .mag_o (mag),
    .neg_o (fneg)
  );

  tfn_norm u_norm (
    .clk_i (clk_i),
    .en_i  (en[SqBase-1:NormBase]),
    .mag_i (mag),
    .neg_i (fneg),
    .thr_i (thr_q),
    .sum_o (sum),
    .c_o   (cval),
    .neg_o (nneg),
    .deg_o (ndeg)
  );

  assign sq_side_in = {ndeg, nneg, cval};

  tfn_isqrt #(
    .SideW (SqSideW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en[DivBase-1:SqBase]),
    .x_i    (sum),
    .side_i (sq_side_in),
    .root_o (root),
    .side_o (sq_side_out)
  );

  tfn_div #(
    .SideW (4)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en[OutIdx-1:DivBase]),
    .root_i (root),
    .c_i    (sq_side_out[3*KeepW-1:0]),
    .side_i (sq_side_out[SqSideW-1:3*KeepW]),
    .q_o    (quo),
    .side_o ({ddeg, dneg})
  );

  // apply signs, saturate +1.0, zero degenerate triangles
  always_comb begin
    logic [2:0][OutW-1:0] nv;
    for (int l = 0; l < 3; l++) begin
      if (ddeg) begin
        nv[l] = '0;
      end else if (dneg[l]) begin
        nv[l] = OutW'(~quo[l] + QuoW'(1));
      end else if (OutW'(quo[l]) == OneCode) begin
        nv[l] = MaxCode;
      end else begin
        nv[l] = OutW'(quo[l]);
      end
    end
    out_d.normal_x   = $signed(nv[0]);
    out_d.normal_y   = $signed(nv[1]);
    out_d.normal_z   = $signed(nv[2]);
    out_d.degenerate = ddeg;
  end

  always_ff @(posedge clk_i) begin
    if (en[OutIdx]) out_q <= out_d;
  end

  assign out_valid_o = v_q[OutIdx];
  assign out_data_o  = out_q;

endmodule

FILE: dv/tb_triangle_face_normal.sv
// Testbench for triangle_face_normal: scoreboard-checked random and directed triangles.
module tb_triangle_face_normal;
  import tfn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 60;
  localparam int WatchLimit  = 4000;
  localparam int HoldCycles  = 300;

  class normal_board;
    tfn_out_t    pending_q[$];
    logic [31:0] threshold;
    int          err_cnt;

    function new();
      threshold = '0;
      err_cnt   = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      err_cnt++;
    endfunction

    function int bit_length(longint unsigned x);
      int n;
      n = 0;
      while (x != 0) begin
        n++;
        x = x >> 1;
      end
      return n;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function tfn_out_t face_normal(tfn_in_t t);
      longint          ax, ay, az, bx, by, bz;
      longint          n[3];
      longint unsigned m[3], c[3];
      longint unsigned len2, sum, r, q;
      bit              neg[3];
      int              bl, s;
      logic [15:0]     o[3];
      tfn_out_t        res;
      ax = longint'(t.v1_x) - longint'(t.v0_x);
      ay = longint'(t.v1_y) - longint'(t.v0_y);
      az = longint'(t.v1_z) - longint'(t.v0_z);
      bx = longint'(t.v2_x) - longint'(t.v0_x);
      by = longint'(t.v2_y) - longint'(t.v0_y);
      bz = longint'(t.v2_z) - longint'(t.v0_z);
      n[0] = ay * bz - az * by;
      n[1] = az * bx - ax * bz;
      n[2] = ax * by - ay * bx;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = n[i] < 0;
        m[i] = neg[i] ? longint'(-n[i]) : n[i];
        if (bit_length(m[i]) > bl) bl = bit_length(m[i]);
      end
      res = '0;
      if (bl <= 16) begin
        len2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        if (len2 <= longint'(threshold)) begin
          res.degenerate = 1'b1;
          return res;
        end
      end
      s = (bl > KeepW) ? bl - KeepW : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        c[i] = m[i] >> s;
        sum += c[i] * c[i];
      end
      r = int_sqrt(sum);
      if (r == 0) r = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((c[i] << FracW) + (r >> 1)) / r;
        if (neg[i]) begin
          q = -q;
        end else if (q > (64'd1 << FracW) - 1) begin
          // +1.0 saturates to the largest code
          q = (64'd1 << FracW) - 1;
        end
        o[i] = q[15:0];
      end
      res.normal_x = o[0];
      res.normal_y = o[1];
      res.normal_z = o[2];
      return res;
    endfunction

    function void note_triangle(tfn_in_t t);
      pending_q.push_back(face_normal(t));
    endfunction

    function void check_normal(tfn_out_t got);
      tfn_out_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_q.pop_front();
      if (got.normal_x !== want.normal_x)
        report($sformatf("normal_x got %h want %h", got.normal_x, want.normal_x));
      if (got.normal_y !== want.normal_y)
        report($sformatf("normal_y got %h want %h", got.normal_y, want.normal_y));
      if (got.normal_z !== want.normal_z)
        report($sformatf("normal_z got %h want %h", got.normal_z, want.normal_z));
      if (got.degenerate !== want.degenerate)
        report($sformatf("degenerate got %b want %b", got.degenerate, want.degenerate));
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  tfn_in_t    in_data_i;
  tfn_out_t   out_data_o;
  logic       psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  normal_board board;
  bit  quiet, hold_req;
  int  idle_cycles = 0;

  triangle_face_normal i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall pattern
  initial begin
    int burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall_i = 1'b1;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_normal(out_data_o);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_triangle_face_normal: done, errors");
      $finish;
    end
  end

  task automatic write_threshold(logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = AddrW'({RegThr, 2'b00});
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.threshold = value;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_triangle(tfn_in_t t);
    int burst;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (burst - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = t;
    do @(posedge clk_i); while (in_stall_o);
    board.note_triangle(t);
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [23:0] small_delta(logic [23:0] base, int span);
    return base + 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic tfn_in_t random_triangle();
    tfn_in_t t;
    logic [7*32-1:0] raw;
    int kind, span;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(tfn_in_t)-1:0];
    kind = $urandom_range(0, 9);
    span = (kind < 6) ? (1 << $urandom_range(0, 12)) : 0;
    if (kind < 6) begin
      // small triangles near the degenerate boundary
      t.v1_x = small_delta(t.v0_x, span); t.v1_y = small_delta(t.v0_y, span);
      t.v1_z = small_delta(t.v0_z, span); t.v2_x = small_delta(t.v0_x, span);
      t.v2_y = small_delta(t.v0_y, span); t.v2_z = small_delta(t.v0_z, span);
    end else if (kind == 6) begin
      // collinear: third vertex repeats the second
      t.v2_x = t.v1_x; t.v2_y = t.v1_y; t.v2_z = t.v1_z;
    end
    return t;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_triangle(random_triangle());
  endtask

  initial begin
    localparam logic signed [23:0] CMax = 24'sh7FFFFF;
    localparam logic signed [23:0] CMin = 24'sh800000;
    localparam logic signed [23:0] COne = 24'sd1;
    tfn_in_t t;
    board = new();
    quiet = 1'b0; hold_req = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_threshold(32'd0);
    send_triangle('0);
    t = '0; t.v1_x = COne; t.v2_y = COne;
    send_triangle(t);                               // +1.0 on z saturates
    t = '0; t.v1_y = COne; t.v2_x = COne;
    send_triangle(t);                               // -1.0 on z is kept
    t = '0; t.v1_y = COne; t.v2_z = COne;
    send_triangle(t);
    t = '0; t.v1_z = COne; t.v2_x = COne;
    send_triangle(t);
    t = '{CMin, CMin, CMin, CMax, CMin, CMin, CMin, CMax, CMax};
    send_triangle(t);
    t = '{CMax, CMax, CMax, CMin, CMax, CMax, CMax, CMin, CMin};
    send_triangle(t);
    t = '{CMin, CMax, CMin, CMax, CMin, CMax, CMax, CMax, CMin};
    send_triangle(t);
    t = '{CMin, CMin, CMin, CMax, CMax, CMax, CMax, CMax, CMax};
    send_triangle(t);                               // collinear, huge edges
    t = '{COne, COne, COne, 24'sd2, 24'sd2, 24'sd2, 24'sd3, 24'sd3, 24'sd3};
    send_triangle(t);
    t = '{24'sd0, 24'sd0, 24'sd0, 24'sd255, 24'sd0, 24'sd0, 24'sd0, 24'sd257, 24'sd0};
    send_triangle(t);                               // |n| exactly at the 16-bit limit
    t = '{24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd4, 24'sd0, -24'sd4, 24'sd3, 24'sd5};
    send_triangle(t);
    drain_pipeline();

    write_threshold(32'hFFFF_FFFF);
    send_triangle(t);
    t = '{24'sd0, 24'sd0, 24'sd0, 24'sd255, 24'sd0, 24'sd0, 24'sd0, 24'sd257, 24'sd0};
    send_triangle(t);
    run_random(150);
    drain_pipeline();

    write_threshold(32'd24);
    t = '{24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd4, 24'sd0, -24'sd4, 24'sd3, 24'sd5};
    send_triangle(t);
    run_random(50);
    hold_req = 1'b1;
    run_random(100);
    drain_pipeline();

    write_threshold($urandom);
    run_random(150);
    drain_pipeline();

    write_threshold(32'd1 << $urandom_range(0, 31));
    quiet = 1'b1;
    run_random(150);
    drain_pipeline();

    if (board.err_cnt == 0) begin
      $display("tb_triangle_face_normal: done, clean");
    end else begin
      $display("tb_triangle_face_normal: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tfn_pkg.sv
sv/tfn_front.sv
sv/tfn_norm.sv
sv/tfn_isqrt.sv
sv/tfn_div.sv
sv/triangle_face_normal.sv
dv/tb_triangle_face_normal.sv
